// File: design/sorted_address_region_table_assert.svh
`ifndef SORTED_ADDRESS_REGION_TABLE_ASSERT_SVH
`define SORTED_ADDRESS_REGION_TABLE_ASSERT_SVH

// same-cycle implication
`define SART_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define SART_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: design/sart_pkg.sv
`timescale 1ns / 1ps

package sart_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int HANDLE_BITS_DEF = 8;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_OVL  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO_M1,
    RD_LO,
    RD_I_M1
  } sart_rd_sel_t;

  typedef struct packed {
    logic         load;
    logic         search_init;
    logic         search_step;
    sart_rd_sel_t rd_sel;
    logic         shift_init;
    logic         shift_write;
    logic         write_new;
    logic         clear;
    logic         resp;
    logic [1:0]   resp_status;
    logic         resp_hit;
  } sart_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       search_open;
    logic       lo_zero;
    logic       lo_lt_count;
    logic       idx_gt_lo;
    logic       below_end;
    logic       ovl_hi;
  } sart_stat_t;

endpackage

// File: design/sart_ctrl.sv
`timescale 1ns / 1ps

module sart_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sart_pkg::sart_stat_t stat,
  output sart_pkg::sart_cmd_t  cmd
);
  import sart_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SCMP,
    S_LK_CMP,
    S_CLO,
    S_CHI_PRE,
    S_CHI,
    S_SH_RD,
    S_SH_WR
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_MID;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        cmd.resp = 1'b1;
        cmd.resp_status = ST_OK;
        if (stat.req == REQ_LOOKUP) begin
          cmd.resp = 1'b0;
          cmd.search_init = 1'b1;
          state_next = S_SRCH;
        end else if (stat.req == REQ_INSERT) begin
          if (stat.full) begin
            cmd.resp_status = ST_FULL;
          end else begin
            cmd.resp = 1'b0;
            cmd.search_init = 1'b1;
            state_next = S_SRCH;
          end
        end else if (stat.req == REQ_CLEAR) begin
          cmd.clear = 1'b1;
        end
      end
      S_SRCH: begin
        if (stat.search_open) begin
          cmd.rd_sel = RD_MID;
          state_next = S_SCMP;
        end else if (stat.req == REQ_LOOKUP) begin
          if (stat.lo_zero) begin
            cmd.resp = 1'b1;
            cmd.resp_status = ST_MISS;
            state_next = S_IDLE;
          end else begin
            cmd.rd_sel = RD_LO_M1;
            state_next = S_LK_CMP;
          end
        end else if (stat.lo_zero) begin
          state_next = S_CHI_PRE;
        end else begin
          cmd.rd_sel = RD_LO_M1;
          state_next = S_CLO;
        end
      end
      S_SCMP: begin
        cmd.search_step = 1'b1;
        state_next = S_SRCH;
      end
      S_LK_CMP: begin
        cmd.resp = 1'b1;
        cmd.resp_hit = stat.below_end;
        cmd.resp_status = stat.below_end ? ST_OK : ST_MISS;
        state_next = S_IDLE;
      end
      S_CLO: begin
        if (stat.below_end) begin
          cmd.resp = 1'b1;
          cmd.resp_status = ST_OVL;
          state_next = S_IDLE;
        end else begin
          state_next = S_CHI_PRE;
        end
      end
      S_CHI_PRE: begin
        if (stat.lo_lt_count) begin
          cmd.rd_sel = RD_LO;
          state_next = S_CHI;
        end else begin
          cmd.shift_init = 1'b1;
          state_next = S_SH_RD;
        end
      end
      S_CHI: begin
        if (stat.ovl_hi) begin
          cmd.resp = 1'b1;
          cmd.resp_status = ST_OVL;
          state_next = S_IDLE;
        end else begin
          cmd.shift_init = 1'b1;
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat.idx_gt_lo) begin
          cmd.rd_sel = RD_I_M1;
          state_next = S_SH_WR;
        end else begin
          cmd.write_new = 1'b1;
          cmd.resp = 1'b1;
          cmd.resp_status = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_SH_WR: begin
        cmd.shift_write = 1'b1;
        state_next = S_SH_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/sart_dp.sv
`timescale 1ns / 1ps

module sart_dp #(
  parameter int MAX_REGIONS = sart_pkg::MAX_REGIONS_DEF,
  parameter int HANDLE_BITS = sart_pkg::HANDLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           req_type,
  input  logic [31:0]          address,
  input  logic [31:0]          region_size,
  input  logic [7:0]           region_handle,
  input  sart_pkg::sart_cmd_t  cmd,
  output sart_pkg::sart_stat_t stat,
  output logic                 done,
  output logic [1:0]           status,
  output logic [7:0]           found_region,
  output logic [31:0]          offset_in_region,
  output logic [32:0]          bytes_left
);
  import sart_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int ENT_W = 32 + 33 + HANDLE_BITS;

  logic [ENT_W-1:0] mem [MAX_REGIONS];
  logic [ENT_W-1:0] rdata;
  logic [IDX_W-1:0] raddr;

  logic [1:0]             req_q;
  logic [31:0]            addr_q;
  logic [32:0]            end_new;
  logic [HANDLE_BITS-1:0] owner_new;
  logic [CNT_W-1:0]       lo, hi, idx, count;

  logic [CNT_W-1:0] mid, lo_m1, idx_m1;
  logic [33:0]      end_sum;
  logic [31:0]      rbase;
  logic [32:0]      rend;
  logic [31:0]      owner_ext;
  logic             go_up;

  assign mid    = lo + ((hi - lo) >> 1);
  assign lo_m1  = lo - CNT_W'(1);
  assign idx_m1 = idx - CNT_W'(1);
  assign rbase  = rdata[ENT_W-1 -: 32];
  assign rend   = rdata[HANDLE_BITS +: 33];
  assign owner_ext = 32'(rdata[HANDLE_BITS-1:0]);
  assign end_sum = ({2'b00, address} + {2'b00, region_size} + 34'd3) & ~34'd3;
  assign go_up = (req_q == REQ_INSERT) ? (rbase < addr_q) : (rbase <= addr_q);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:   raddr = mid[IDX_W-1:0];
      RD_LO_M1: raddr = lo_m1[IDX_W-1:0];
      RD_LO:    raddr = lo[IDX_W-1:0];
      RD_I_M1:  raddr = idx_m1[IDX_W-1:0];
      default:  raddr = mid[IDX_W-1:0];
    endcase
  end

  always_comb begin
    stat.req         = req_q;
    stat.full        = (count == CNT_W'(MAX_REGIONS));
    stat.search_open = (lo < hi);
    stat.lo_zero     = (lo == '0);
    stat.lo_lt_count = (lo < count);
    stat.idx_gt_lo   = (idx > lo);
    stat.below_end   = ({1'b0, addr_q} < rend);
    stat.ovl_hi      = (rbase == addr_q) || ({1'b0, rbase} < end_new);
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.shift_write) begin
      mem[idx[IDX_W-1:0]] <= rdata;
    end else if (cmd.write_new) begin
      mem[lo[IDX_W-1:0]] <= {addr_q, end_new, owner_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req_type;
      addr_q    <= address;
      end_new   <= (end_sum > 34'h1_0000_0000) ? 33'h1_0000_0000 : end_sum[32:0];
      owner_new <= HANDLE_BITS'(32'(region_handle));
    end
    if (cmd.search_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.search_step) begin
      if (go_up) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.shift_init) begin
      idx <= count;
    end else if (cmd.shift_write) begin
      idx <= idx_m1;
    end
    status           <= cmd.resp_status;
    found_region     <= cmd.resp_hit ? owner_ext[7:0] : 8'd0;
    offset_in_region <= cmd.resp_hit ? (addr_q - rbase) : 32'd0;
    bytes_left       <= cmd.resp_hit ? (rend - {1'b0, addr_q}) : 33'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.resp;
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.write_new) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

// File: design/sorted_address_region_table.sv
`timescale 1ns / 1ps

// Sorted table of non-overlapping address regions. Pulse start while busy is
// low to hand in one request; busy stays high until the result beat, which is
// shown for one cycle with done high and cannot be held off. A lookup runs a
// binary search over the single read port of the region memory; an insert
// adds two neighbor checks and a read and a write for each entry shifted up.
module sorted_address_region_table #(
  parameter int MAX_REGIONS = sart_pkg::MAX_REGIONS_DEF,
  parameter int HANDLE_BITS = sart_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] address,
  input  logic [31:0] region_size,
  input  logic [7:0]  region_handle,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  found_region,
  output logic [31:0] offset_in_region,
  output logic [32:0] bytes_left
);
  import sart_pkg::*;

  sart_cmd_t  cmd;
  sart_stat_t stat;

  sart_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sart_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .req_type         (req_type),
    .address          (address),
    .region_size      (region_size),
    .region_handle    (region_handle),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .status           (status),
    .found_region     (found_region),
    .offset_in_region (offset_in_region),
    .bytes_left       (bytes_left)
  );

`include "sorted_address_region_table_assert.svh"

  `SART_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SART_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `SART_ASSERT_IMP(a_hit_only_ok, clk, rst, done && (bytes_left != 33'd0), status == ST_OK)

endmodule
